// File: rtl/core/srht_pkg.sv
// ---------------------------------------------------------------------------
// srht_pkg
// Shared types and constants for the segment / rectangle hit test pipeline.
// ---------------------------------------------------------------------------
package srht_pkg;

    // Rectangle register width (integer pixels, two's complement)
    localparam int RECT_W = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RECT_LEFT   = 2'd0,
        REG_RECT_TOP    = 2'd1,
        REG_RECT_RIGHT  = 2'd2,
        REG_RECT_BOTTOM = 2'd3
    } t_cfg_reg;

    // Side order used for the per-side flag vectors
    localparam int SIDE_TOP    = 0;
    localparam int SIDE_RIGHT  = 1;
    localparam int SIDE_BOTTOM = 2;
    localparam int SIDE_LEFT   = 3;
    localparam int NUM_SIDES   = 4;

    // Flags worked out from compares in the second stage
    typedef struct packed {
        logic                 in_rect; // an endpoint lies in the closed rectangle
        logic [NUM_SIDES-1:0] split;   // the side line separates the two endpoints
    } t_s2_flags;

endpackage

// File: rtl/core/segment_rectangle_hit_test_unit.sv
// Pipeline: four register stages; o_valid is the valid bit of the fourth
// stage, which an accepted item reaches after passing through stages 1 to 3.
// Throughput: one item per cycle while o_stall is low; o_stall rises only when
// all four stages are full and the output is stalled, so bubbles are filled.
// The deepest step is the signed multiply in the third stage.
// Reset: all stage valid bits clear and the four rectangle registers go to 0.
// ---------------------------------------------------------------------------
// segment_rectangle_hit_test_unit
// Reports whether a fixed-point line segment touches or strictly crosses an
// axis-aligned rectangle held in four configuration registers.
// ---------------------------------------------------------------------------
module segment_rectangle_hit_test_unit
    import srht_pkg::*;
#(
    parameter int COORD_INT_BITS  = 16,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // configuration write port
    input  logic                                          i_cfg_wr_en,
    input  logic [1:0]                                    i_cfg_index,
    input  logic [RECT_W-1:0]                             i_cfg_data,
    // input channel
    input  logic                                          i_valid,
    output logic                                          o_stall,
    input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] i_start_x,
    input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] i_start_y,
    input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] i_end_x,
    input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] i_end_y,
    // output channel
    output logic                                          o_valid,
    input  logic                                          i_stall,
    output logic                                          o_hit
);

    localparam int CW  = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int RW  = RECT_W + COORD_FRAC_BITS;
    localparam int PW  = (CW > RW) ? CW : RW;   // common coordinate width
    localparam int DW  = PW + 1;                 // difference width
    localparam int PRW = 2 * DW;                 // product width
    localparam int EW  = PRW + 1;                // cross-product width

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic signed [RECT_W-1:0] r_rect_left, r_rect_top, r_rect_right, r_rect_bottom;

    // write the addressed rectangle register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left   <= '0;
            r_rect_top    <= '0;
            r_rect_right  <= '0;
            r_rect_bottom <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_RECT_LEFT:   r_rect_left   <= i_cfg_data;
                REG_RECT_TOP:    r_rect_top    <= i_cfg_data;
                REG_RECT_RIGHT:  r_rect_right  <= i_cfg_data;
                REG_RECT_BOTTOM: r_rect_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scale the rectangle into the coordinate format
    logic signed [PW-1:0] x0, y0, x1, y1;
    assign x0 = PW'(r_rect_left)   <<< COORD_FRAC_BITS;
    assign y0 = PW'(r_rect_top)    <<< COORD_FRAC_BITS;
    assign x1 = PW'(r_rect_right)  <<< COORD_FRAC_BITS;
    assign y1 = PW'(r_rect_bottom) <<< COORD_FRAC_BITS;

    // -----------------------------------------------------------------------
    // Stall chain: a stage holds when it is full and the next one holds
    // -----------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic hold1, hold2, hold3, hold4;

    assign hold4   = r_v4 && i_stall;
    assign hold3   = r_v3 && hold4;
    assign hold2   = r_v2 && hold3;
    assign hold1   = r_v1 && hold2;
    assign o_stall = hold1;

    // advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (!hold1) r_v1 <= i_valid;
            if (!hold2) r_v2 <= r_v1;
            if (!hold3) r_v3 <= r_v2;
            if (!hold4) r_v4 <= r_v3;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 1: capture the endpoints
    // -----------------------------------------------------------------------
    logic signed [CW-1:0] r1_ax, r1_ay, r1_bx, r1_by;

    always_ff @(posedge i_clk) begin
        if (!hold1) begin
            r1_ax <= i_start_x;
            r1_ay <= i_start_y;
            r1_bx <= i_end_x;
            r1_by <= i_end_y;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 2: differences, containment and side-line sign tests
    // -----------------------------------------------------------------------
    logic signed [PW-1:0] ax, ay, bx, by;
    assign ax = PW'(r1_ax);
    assign ay = PW'(r1_ay);
    assign bx = PW'(r1_bx);
    assign by = PW'(r1_by);

    logic signed [DW-1:0] n_dx, n_dy, n_x0a, n_x1a, n_y0a, n_y1a;
    assign n_dx  = DW'(bx) - DW'(ax);
    assign n_dy  = DW'(by) - DW'(ay);
    assign n_x0a = DW'(x0) - DW'(ax);
    assign n_x1a = DW'(x1) - DW'(ax);
    assign n_y0a = DW'(y0) - DW'(ay);
    assign n_y1a = DW'(y1) - DW'(ay);

    // A product is positive when both factors are nonzero with equal sign;
    // the side direction is one factor, the endpoint offset the other.
    logic      a_top_gt, a_top_lt, a_rgt_gt, a_rgt_lt;
    logic      top_a, top_b, rgt_a, rgt_b, bot_a, bot_b, lft_a, lft_b;
    t_s2_flags n_flags;

    always_comb begin
        a_top_gt = x1 > x0;
        a_top_lt = x1 < x0;
        a_rgt_gt = y1 > y0;
        a_rgt_lt = y1 < y0;
        // top side: (x1-x0)*(py-y0)
        top_a = (a_top_gt && ay > y0) || (a_top_lt && ay < y0);
        top_b = (a_top_gt && by > y0) || (a_top_lt && by < y0);
        // right side: (y1-y0)*(x1-px)
        rgt_a = (a_rgt_gt && ax < x1) || (a_rgt_lt && ax > x1);
        rgt_b = (a_rgt_gt && bx < x1) || (a_rgt_lt && bx > x1);
        // bottom side: (x0-x1)*(py-y1)
        bot_a = (a_top_lt && ay > y1) || (a_top_gt && ay < y1);
        bot_b = (a_top_lt && by > y1) || (a_top_gt && by < y1);
        // left side: (y1-y0)*(px-x0)
        lft_a = (a_rgt_gt && ax > x0) || (a_rgt_lt && ax < x0);
        lft_b = (a_rgt_gt && bx > x0) || (a_rgt_lt && bx < x0);

        n_flags.split[SIDE_TOP]    = top_a != top_b;
        n_flags.split[SIDE_RIGHT]  = rgt_a != rgt_b;
        n_flags.split[SIDE_BOTTOM] = bot_a != bot_b;
        n_flags.split[SIDE_LEFT]   = lft_a != lft_b;
        n_flags.in_rect = (ax >= x0 && ax <= x1 && ay >= y0 && ay <= y1) ||
                          (bx >= x0 && bx <= x1 && by >= y0 && by <= y1);
    end

    logic signed [DW-1:0] r2_dx, r2_dy, r2_x0a, r2_x1a, r2_y0a, r2_y1a;
    t_s2_flags            r2_flags;

    always_ff @(posedge i_clk) begin
        if (!hold2) begin
            r2_dx    <= n_dx;
            r2_dy    <= n_dy;
            r2_x0a   <= n_x0a;
            r2_x1a   <= n_x1a;
            r2_y0a   <= n_y0a;
            r2_y1a   <= n_y1a;
            r2_flags <= n_flags;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 3: the four shared products of the corner cross products
    // -----------------------------------------------------------------------
    logic signed [PRW-1:0] n_py0, n_py1, n_px0, n_px1;
    assign n_py0 = r2_dx * r2_y0a;
    assign n_py1 = r2_dx * r2_y1a;
    assign n_px0 = r2_dy * r2_x0a;
    assign n_px1 = r2_dy * r2_x1a;

    logic signed [PRW-1:0] r3_py0, r3_py1, r3_px0, r3_px1;
    t_s2_flags             r3_flags;

    always_ff @(posedge i_clk) begin
        if (!hold3) begin
            r3_py0   <= n_py0;
            r3_py1   <= n_py1;
            r3_px0   <= n_px0;
            r3_px1   <= n_px1;
            r3_flags <= r2_flags;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 4: corner sides of the segment line and the final decision
    // -----------------------------------------------------------------------
    logic signed [EW-1:0] e_c0, e_c1, e_c2, e_c3;
    logic [3:0]           corner_pos;
    logic [NUM_SIDES-1:0] side_cross;
    logic                 n_hit;

    always_comb begin
        // corners: top-left, top-right, bottom-right, bottom-left
        e_c0 = EW'(r3_py0) - EW'(r3_px0);
        e_c1 = EW'(r3_py0) - EW'(r3_px1);
        e_c2 = EW'(r3_py1) - EW'(r3_px1);
        e_c3 = EW'(r3_py1) - EW'(r3_px0);
        corner_pos[0] = !e_c0[EW-1] && (e_c0 != '0);
        corner_pos[1] = !e_c1[EW-1] && (e_c1 != '0);
        corner_pos[2] = !e_c2[EW-1] && (e_c2 != '0);
        corner_pos[3] = !e_c3[EW-1] && (e_c3 != '0);
        side_cross[SIDE_TOP]    = r3_flags.split[SIDE_TOP]    &&
                                  (corner_pos[0] != corner_pos[1]);
        side_cross[SIDE_RIGHT]  = r3_flags.split[SIDE_RIGHT]  &&
                                  (corner_pos[1] != corner_pos[2]);
        side_cross[SIDE_BOTTOM] = r3_flags.split[SIDE_BOTTOM] &&
                                  (corner_pos[2] != corner_pos[3]);
        side_cross[SIDE_LEFT]   = r3_flags.split[SIDE_LEFT]   &&
                                  (corner_pos[3] != corner_pos[0]);
        n_hit = r3_flags.in_rect || (|side_cross);
    end

    logic r4_hit;

    always_ff @(posedge i_clk) begin
        if (!hold4) begin
            r4_hit <= n_hit;
        end
    end

    assign o_valid = r_v4;
    assign o_hit   = r4_hit;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    // a full pipeline with a stalled output pushes back on the input
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && i_stall) |-> o_stall)
        else $error("full pipeline did not stall the input");

    // an accepted item always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted item lost at the first stage");

    // an item leaving the third stage reaches the output
    a_s3_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !hold4) |=> o_valid)
        else $error("item lost between the third stage and the output");

    // the output stage never empties while it is stalled
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hold4 |=> (r_v4 && $stable(r4_hit)))
        else $error("stalled result changed or vanished");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - segment / rectangle hit test unit
// Drives line segments through the unit under several rectangle settings,
// first from a short table of hand-picked cases and then at random, and
// compares every returned hit flag with the table's expected value or a local exact-integer prediction.
// ---------------------------------------------------------------------------
module tb;
    import srht_pkg::*;

    localparam int     INT_BITS  = 16;
    localparam int     FRAC_BITS = 4;
    localparam int     CW        = INT_BITS + FRAC_BITS;
    localparam int     LATENCY   = 4;
    localparam longint CMIN      = -(longint'(1) <<< (CW - 1));
    localparam longint CMAX      = (longint'(1) <<< (CW - 1)) - 1;
    localparam int     PHASES    = 11;
    localparam int     PER_PHASE = 50;

    typedef logic signed [CW-1:0] t_coord;

    // One row of the hand-picked table; want < 0 means use the prediction
    typedef struct {
        int l, t, r, b;
        int sx, sy, ex, ey;
        int want;
    } t_seg_row;

    typedef struct {
        logic hit;
        int   tag;
    } t_hit_expect;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [1:0]               i_cfg_index;
    logic [RECT_W-1:0]        i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    t_coord                   i_start_x;
    t_coord                   i_start_y;
    t_coord                   i_end_x;
    t_coord                   i_end_y;
    logic                     o_valid;
    logic                     i_stall;
    logic                     o_hit;

    // Local copy of the rectangle registers
    logic signed [RECT_W-1:0] rect_left_q;
    logic signed [RECT_W-1:0] rect_top_q;
    logic signed [RECT_W-1:0] rect_right_q;
    logic signed [RECT_W-1:0] rect_bottom_q;

    t_hit_expect              hit_queue [$];
    t_hit_expect              oldest;
    t_seg_row                 dir_rows [];
    int                       err_count;
    int                       seg_count;
    int                       quiet_sends;

    segment_rectangle_hit_test_unit #(
        .COORD_INT_BITS  (INT_BITS),
        .COORD_FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // true when a*b - c*d is strictly positive; 64 bits hold it exactly
    function automatic bit diff_positive(longint a, longint b, longint c, longint d);
        return (a * b - c * d) > 0;
    endfunction

    // Strict crossing of segment A-B with side C-D, zero taken as non-positive
    function automatic bit sides_cross(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy, longint dx, longint dy);
        bit s1, s2, s3, s4;
        s1 = diff_positive(bx - ax, cy - ay, by - ay, cx - ax);
        s2 = diff_positive(bx - ax, dy - ay, by - ay, dx - ax);
        s3 = diff_positive(dx - cx, ay - cy, dy - cy, ax - cx);
        s4 = diff_positive(dx - cx, by - cy, dy - cy, bx - cx);
        return (s1 != s2) && (s3 != s4);
    endfunction

    function automatic logic predict_hit(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        longint ax, ay, bx, by, x0, y0, x1, y1;
        bit     in_a, in_b;
        ax = longint'(sx);
        ay = longint'(sy);
        bx = longint'(ex);
        by = longint'(ey);
        x0 = longint'(rect_left_q) * (longint'(1) <<< FRAC_BITS);
        y0 = longint'(rect_top_q) * (longint'(1) <<< FRAC_BITS);
        x1 = longint'(rect_right_q) * (longint'(1) <<< FRAC_BITS);
        y1 = longint'(rect_bottom_q) * (longint'(1) <<< FRAC_BITS);
        in_a = (ax >= x0) && (ax <= x1) && (ay >= y0) && (ay <= y1);
        in_b = (bx >= x0) && (bx <= x1) && (by >= y0) && (by <= y1);
        if (in_a || in_b)
            return 1'b1;
        // top, right, bottom, left
        return sides_cross(ax, ay, bx, by, x0, y0, x1, y0) ||
               sides_cross(ax, ay, bx, by, x1, y0, x1, y1) ||
               sides_cross(ax, ay, bx, by, x1, y1, x0, y1) ||
               sides_cross(ax, ay, bx, by, x0, y1, x0, y0);
    endfunction

    // Pick a coordinate: full range, near the rectangle span, at or beside an edge, or at a range limit
    function automatic t_coord rand_coord(longint lo, longint hi);
        longint      a, b, span, v;
        int unsigned mode;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        span = b - a + 64;
        mode = $urandom_range(0, 9);
        if (mode < 3) begin
            v = longint'(t_coord'($urandom));
        end else if (mode < 8) begin
            v = a - span / 2 + longint'($urandom_range(0, 32'(span * 2)));
        end else begin
            case ($urandom_range(0, 5))
                0: v = a;
                1: v = b;
                2: v = a - 1;
                3: v = b + 1;
                4: v = CMIN;
                default: v = CMAX;
            endcase
        end
        if (v < CMIN) v = CMIN;
        if (v > CMAX) v = CMAX;
        return t_coord'(v);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        err_count++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [RECT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_RECT_LEFT:   rect_left_q   = val;
            REG_RECT_TOP:    rect_top_q    = val;
            REG_RECT_RIGHT:  rect_right_q  = val;
            REG_RECT_BOTTOM: rect_bottom_q = val;
            default: ;
        endcase
    endtask

    task automatic write_rect(input int l, input int t, input int r, input int b);
        write_reg(REG_RECT_RIGHT,  r[RECT_W-1:0]);
        write_reg(REG_RECT_LEFT,   l[RECT_W-1:0]);
        write_reg(REG_RECT_BOTTOM, b[RECT_W-1:0]);
        write_reg(REG_RECT_TOP,    t[RECT_W-1:0]);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Drop valid, hold until every expected hit is back, then let the pipe empty
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (hit_queue.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic send_segment(input t_coord sx, input t_coord sy,
                                input t_coord ex, input t_coord ey, input int want);
        int          gap;
        t_hit_expect entry;
        if (quiet_sends > 0) begin
            gap = 0;
            quiet_sends--;
        end else if ($urandom_range(0, 29) == 0) begin
            gap = 0;
            quiet_sends = 30;
        end else begin
            gap = $urandom_range(0, 8);
        end
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x   <= ex;
        i_end_y   <= ey;
        do @(posedge i_clk); while (o_stall);
        entry.hit = (want < 0) ? predict_hit(sx, sy, ex, ey) : want[0];
        entry.tag = seg_count;
        seg_count++;
        hit_queue = {hit_queue, entry};
    endtask

    // Check each returned item against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (hit_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected item, hit=%0b", o_hit));
            end else begin
                oldest = hit_queue.pop_front();
                if (o_hit !== oldest.hit)
                    report_mismatch($sformatf("segment %0d hit=%0b, want %0b",
                                              oldest.tag, o_hit, oldest.hit));
            end
        end
    end

    // Result side: stall a random number of cycles before taking each item
    initial begin : result_sink
        int wait_cycles;
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (quiet > 0) begin
                wait_cycles = 0;
                quiet--;
            end else if ($urandom_range(0, 29) == 0) begin
                wait_cycles = 0;
                quiet = 30;
            end else begin
                wait_cycles = $urandom_range(0, 8);
            end
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        t_coord sx, sy, ex, ey;
        longint x0, y0, x1, y1;
        int     l, t, r, b, pick, tmp;

        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = REG_RECT_LEFT;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_start_x   = '0;
        i_start_y   = '0;
        i_end_x     = '0;
        i_end_y     = '0;
        rect_left_q   = '0;
        rect_top_q    = '0;
        rect_right_q  = '0;
        rect_bottom_q = '0;
        err_count   = 0;
        seg_count   = 0;
        quiet_sends = 0;

        dir_rows = '{
            // reset rectangle: the single point at the origin
            '{0, 0, 0, 0,            0, 0, 0, 0,                   1},
            '{0, 0, 0, 0,            16, 16, 32, 32,              -1},
            '{0, 0, 0, 0,            -16, -16, 16, 16,            -1},
            // ordinary rectangle, 160..320 once scaled
            '{10, 10, 20, 20,        240, 240, 240, 240,           1},
            '{10, 10, 20, 20,        0, 0, 0, 0,                   0},
            '{10, 10, 20, 20,        160, 160, -400, -400,         1},
            '{10, 10, 20, 20,        1000, 1000, 320, 320,         1},
            '{10, 10, 20, 20,        0, 240, 480, 240,            -1},
            '{10, 10, 20, 20,        0, 0, 0, 480,                -1},
            '{10, 10, 20, 20,        0, 160, 480, 160,            -1},
            '{10, 10, 20, 20,        0, 320, 320, 0,              -1},
            '{10, 10, 20, 20,        159, 240, -100, 240,         -1},
            '{10, 10, 20, 20,        -524288, -524288, 524287, 524287, -1},
            '{10, 10, 20, 20,        524287, -524288, -524288, 524287, -1},
            // inverted rectangle: nothing is inside
            '{20, 20, 10, 10,        240, 240, 240, 240,           0},
            '{20, 20, 10, 10,        0, 240, 480, 240,            -1},
            // widest rectangle
            '{-32768, -32768, 32767, 32767, -524288, -524288, -524288, -524288, 1},
            '{-32768, -32768, 32767, 32767, 524272, 524272, 524272, 524272, 1},
            '{-32768, -32768, 32767, 32767, 524287, 0, 524287, 0,  0},
            '{-32768, -32768, 32767, 32767, 524287, 524287, -524288, -524288, 1},
            '{-32768, -32768, 32767, 32767, 524273, -524288, 524287, 524287, -1},
            // point rectangles at the top and bottom of the register range
            '{32767, 32767, 32767, 32767, 524272, 524272, 0, 0,    1},
            '{32767, 32767, 32767, 32767, 524287, 524287, 524287, 0, -1},
            '{-32768, -32768, -32768, -32768, -524288, -524288, 524287, 524287, 1}
        };

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table, reprogramming the rectangle only when it changes
        foreach (dir_rows[i]) begin
            if (dir_rows[i].l[RECT_W-1:0] != rect_left_q ||
                dir_rows[i].t[RECT_W-1:0] != rect_top_q ||
                dir_rows[i].r[RECT_W-1:0] != rect_right_q ||
                dir_rows[i].b[RECT_W-1:0] != rect_bottom_q) begin
                drain_results();
                write_rect(dir_rows[i].l, dir_rows[i].t, dir_rows[i].r, dir_rows[i].b);
            end
            send_segment(t_coord'(dir_rows[i].sx), t_coord'(dir_rows[i].sy),
                         t_coord'(dir_rows[i].ex), t_coord'(dir_rows[i].ey),
                         dir_rows[i].want);
        end

        // Random phases, one rectangle setting each
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin l = 10;     t = 10;     r = 20;    b = 20;    end
                1: begin l = -32768; t = -32768; r = 32767; b = 32767; end
                2: begin l = -32768; t = -32768; r = -32768; b = -32768; end
                3: begin l = 32767;  t = 32767;  r = 32767; b = 32767; end
                4: begin l = 50;     t = -20;    r = -50;   b = 20;    end
                5: begin l = -100;   t = 100;    r = 100;   b = -100;  end
                6: begin
                    l = int'($urandom_range(0, 65535)) - 32768;
                    r = int'($urandom_range(0, 65535)) - 32768;
                    t = int'($urandom_range(0, 65535)) - 32768;
                    b = int'($urandom_range(0, 65535)) - 32768;
                    if (l > r) begin tmp = l; l = r; r = tmp; end
                    if (t > b) begin tmp = t; t = b; b = tmp; end
                end
                7: begin
                    l = int'($urandom_range(0, 65535)) - 32768;
                    r = int'($urandom_range(0, 65535)) - 32768;
                    t = int'($urandom_range(0, 65535)) - 32768;
                    b = int'($urandom_range(0, 65535)) - 32768;
                end
                8: begin l = -5;     t = 0;      r = 5;     b = 0;     end
                9: begin l = 0;      t = 0;      r = 0;     b = 0;     end
                default: begin
                    l = int'($urandom_range(0, 4000)) - 2000;
                    t = int'($urandom_range(0, 4000)) - 2000;
                    r = l + int'($urandom_range(0, 40));
                    b = t + int'($urandom_range(0, 40));
                end
            endcase
            drain_results();
            write_rect(l, t, r, b);
            x0 = longint'(rect_left_q) * (longint'(1) <<< FRAC_BITS);
            y0 = longint'(rect_top_q) * (longint'(1) <<< FRAC_BITS);
            x1 = longint'(rect_right_q) * (longint'(1) <<< FRAC_BITS);
            y1 = longint'(rect_bottom_q) * (longint'(1) <<< FRAC_BITS);

            for (int k = 0; k < PER_PHASE; k++) begin
                // in phase 3, hold off mid-phase until the pipe has handed everything back
                if (ph == 3 && k == PER_PHASE / 2)
                    drain_results();
                sx = rand_coord(x0, x1);
                sy = rand_coord(y0, y1);
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    ex = sx;
                    ey = sy;
                end else if (pick == 1) begin
                    ex = rand_coord(x0, x1);
                    ey = sy;
                end else if (pick == 2) begin
                    ex = sx;
                    ey = rand_coord(y0, y1);
                end else begin
                    ex = rand_coord(x0, x1);
                    ey = rand_coord(y0, y1);
                end
                send_segment(sx, sy, ex, ey, -1);
            end
        end

        // Let everything come back and check nothing extra turns up
        drain_results();
        repeat (LATENCY * 3) @(posedge i_clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
